/* rtl/isq64_pkg.sv */
// Package for the scaled 64-bit integer square root block.
// Holds the widths, the scaling constant and the sequencer state type.
// No dependencies.
package isq64_pkg;

  localparam int unsigned OperandWidth = 63;
  localparam int unsigned InDataWidth  = 64;
  localparam int unsigned RootWidth    = 32;
  localparam int unsigned FracBits     = 8;
  localparam int unsigned ResultWidth  = RootWidth + FracBits;
  localparam int unsigned RemWidth     = RootWidth + 2;
  localparam int unsigned StepCount    = InDataWidth / 2;
  localparam int unsigned StepCntWidth = $clog2(StepCount);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

endpackage

/* rtl/isqrt64_scaled_unit.sv */
// Top level of the scaled 64-bit integer square root block.
// Depends on isq64_pkg for widths, the scaling constant and the state type.
//
// Channel  Dir  Handshake           Payload
// s_*      in   s_tvalid/s_tready   s_tdata[62:0] operand, bits 63 zero
// m_*      out  m_tvalid/m_tready   m_tdata[39:0] root_scaled
//
// Each operand passes through one shared subtract-and-compare unit, which
// retires two operand bits and one root bit per cycle once the transaction is
// taken in; after the last step the root is loaded into the output register.
// A new operand is taken while the previous result still waits in the output
// register. Reset (rst, synchronous) returns the sequencer to idle and drops
// m_tvalid. If the output register is still full when a root is finished, the
// sequencer holds the root until m_tready frees the register.
module isqrt64_scaled_unit
  import isq64_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [InDataWidth-1:0] s_tdata,   // [62:0] operand, [63] zero fill
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [ResultWidth-1:0] m_tdata    // [39:0] root_scaled
);

  state_t                  state, state_next;
  logic [StepCntWidth-1:0] step_cnt;
  logic [InDataWidth-1:0]  op_shift;
  logic [RemWidth-1:0]     rem;
  logic [RootWidth-1:0]    root;

  logic [RemWidth+1:0]     rem_shifted;
  logic [RemWidth+1:0]     trial;
  logic                    trial_fits;
  logic [RemWidth-1:0]     rem_next;
  logic [RootWidth-1:0]    root_next;

  logic                    last_step;
  logic                    out_free;
  logic                    step_en;
  logic                    result_load;
  logic [RootWidth-1:0]    result_root;

  // Shared step unit: bring down two operand bits and test 4*root + 1.
  always_comb begin
    rem_shifted = {rem, op_shift[InDataWidth-1 -: 2]};
    trial       = {2'b00, root, 2'b01};
    trial_fits  = (rem_shifted >= trial);
    if (trial_fits) begin
      rem_next  = RemWidth'(rem_shifted - trial);
      root_next = {root[RootWidth-2:0], 1'b1};
    end else begin
      rem_next  = rem_shifted[RemWidth-1:0];
      root_next = {root[RootWidth-2:0], 1'b0};
    end
  end

  assign last_step = (step_cnt == StepCntWidth'(StepCount - 1));
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (last_step) state_next = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    step_en     = 1'b0;
    result_load = 1'b0;
    result_root = root;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_RUN: begin
        step_en     = 1'b1;
        result_load = last_step && out_free;
        result_root = root_next;
      end
      ST_HOLD: begin
        result_load = m_tready;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (s_tvalid && s_tready) begin
        step_cnt <= '0;
      end else if (step_en) begin
        step_cnt <= step_cnt + 1'b1;
      end
      if (result_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_shift <= {1'b0, s_tdata[OperandWidth-1:0]};
      rem      <= '0;
      root     <= '0;
    end else if (step_en) begin
      op_shift <= {op_shift[InDataWidth-3:0], 2'b00};
      rem      <= rem_next;
      root     <= root_next;
    end
    if (result_load) begin
      m_tdata <= {result_root, {FracBits{1'b0}}};
    end
  end

endmodule
